[hdl/assert_macros.svh]
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset.
`define RGBATM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgbatm assertion failed");

// Expression must never be true at a clock edge out of reset.
`define RGBATM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("rgbatm forbidden condition seen");

`else

`define RGBATM_ASSERT(lbl, prop)
`define RGBATM_NEVER(lbl, expr)

`endif

`endif

[hdl/rgbatm_pkg.sv]
package rgbatm_pkg;

  localparam int unsigned CH_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [2:0] {
    MODE_ADD_OVER = 3'd0,
    MODE_ADD_PIN  = 3'd1,
    MODE_SUB_OVER = 3'd2,
    MODE_SUB_PIN  = 3'd3,
    MODE_MIN      = 3'd4,
    MODE_MAX      = 3'd5,
    MODE_BLEND    = 3'd6
  } mode_e;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_RED_LEVEL   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OP_GRN_LEVEL   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OP_BLUE_LEVEL  = 8'd3;

  localparam logic [CH_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef struct packed {
    logic [CH_W-1:0] first_red;
    logic [CH_W-1:0] first_green;
    logic [CH_W-1:0] first_blue;
    logic [CH_W-1:0] second_red;
    logic [CH_W-1:0] second_green;
    logic [CH_W-1:0] second_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    mode_e           mode;
    logic [CH_W-1:0] op_red;
    logic [CH_W-1:0] op_grn;
    logic [CH_W-1:0] op_blue;
  } cfg_t;

endpackage

[hdl/rgbatm_cfg_regs.sv]
module rgbatm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [rgbatm_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [rgbatm_pkg::CFG_DAT_W-1:0]  wr_data_i,
  output rgbatm_pkg::cfg_t                  cfg_o
);

  rgbatm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        rgbatm_pkg::REG_MODE_SELECT:    cfg_d.mode     = rgbatm_pkg::mode_e'(wr_data_i[2:0]);
        rgbatm_pkg::REG_OP_RED_LEVEL:   cfg_d.op_red   = wr_data_i;
        rgbatm_pkg::REG_OP_GRN_LEVEL:   cfg_d.op_grn   = wr_data_i;
        rgbatm_pkg::REG_OP_BLUE_LEVEL:  cfg_d.op_blue  = wr_data_i;
        default: begin
          // unmapped index: write is dropped
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: rgbatm_pkg::MODE_ADD_OVER, op_red: '0, op_grn: '0, op_blue: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/rgbatm_channel.sv]
module rgbatm_channel (
  input  rgbatm_pkg::mode_e               mode_i,
  input  logic [rgbatm_pkg::CH_W-1:0]     first_i,
  input  logic [rgbatm_pkg::CH_W-1:0]     second_i,
  input  logic [rgbatm_pkg::CH_W-1:0]     op_i,
  output logic [rgbatm_pkg::CH_W-1:0]     res_o
);

  localparam int unsigned W = rgbatm_pkg::CH_W;

  logic [W:0]       sum;
  logic [W:0]       diff;      // two's complement, bit W is the sign
  logic [W-1:0]     weight_b;
  logic [2*W-1:0]   prod_a;
  logic [2*W-1:0]   prod_b;
  logic [2*W:0]     blend_sum;
  logic [2*W+1:0]   blend_adj;
  logic [W-1:0]     blend_q;

  assign sum  = {1'b0, first_i} + {1'b0, second_i};
  assign diff = {1'b0, first_i} - {1'b0, second_i};

  assign weight_b  = rgbatm_pkg::FULL_SCALE - op_i;
  assign prod_a    = first_i * op_i;
  assign prod_b    = second_i * weight_b;
  assign blend_sum = {1'b0, prod_a} + {1'b0, prod_b};

  // x / 65535 for x <= 65535^2 is (x + (x >> 16) + 1) >> 16
  assign blend_adj = {1'b0, blend_sum} + {{(W+1){1'b0}}, blend_sum[2*W:W]} +
                     {{(2*W+1){1'b0}}, 1'b1};
  assign blend_q   = blend_adj[2*W-1:W];

  always_comb begin
    case (mode_i)
      rgbatm_pkg::MODE_ADD_OVER: res_o = sum[W-1:0];
      rgbatm_pkg::MODE_ADD_PIN:  res_o = (sum < {1'b0, op_i}) ? sum[W-1:0] : op_i;
      rgbatm_pkg::MODE_SUB_OVER: res_o = diff[W-1:0];
      rgbatm_pkg::MODE_SUB_PIN: begin
        // negative difference always falls below the limit
        if (diff[W] || (diff[W-1:0] <= op_i)) begin
          res_o = op_i;
        end else begin
          res_o = diff[W-1:0];
        end
      end
      rgbatm_pkg::MODE_MIN:      res_o = (first_i < second_i) ? first_i : second_i;
      rgbatm_pkg::MODE_MAX:      res_o = (first_i > second_i) ? first_i : second_i;
      rgbatm_pkg::MODE_BLEND:    res_o = blend_q;
      default:                   res_o = '0;
    endcase
  end

endmodule

[hdl/rgb_arithmetic_transfer_modes.sv]
// Per-pixel arithmetic combiner for two RGB sources, 16 bits per channel.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one word per
// pixel pair: first and second source red, green, blue. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns one combined pixel word
// for each input word, in order.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
// writes mode_select (0) and the red, green, blue operation levels (1..3).
// It is always ready; write it only while no pixel is in flight.
//
// An accepted word passes through an input register, then the per-channel
// combiner (one 16x16 multiply pair for blend) feeding the output register.
// Throughput is one word per cycle while the receiver keeps up.
// If the receiver stalls, the output register holds its word and the input
// register still takes one more; after that in_ready_o drops until the
// output drains. Reset empties both stages and clears all config to 0
// (add-over mode, levels 0).
`include "assert_macros.svh"

module rgb_arithmetic_transfer_modes (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rgbatm_pkg::pix_in_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rgbatm_pkg::pix_out_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rgbatm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rgbatm_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  rgbatm_pkg::cfg_t     cfg;
  rgbatm_pkg::pix_in_t  in_q;
  rgbatm_pkg::pix_out_t res;
  rgbatm_pkg::pix_out_t out_q;
  logic                 in_valid_q, in_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_load;
  logic                 out_load;

  // Config registers: writes land in the next cycle, no backpressure.
  assign cfg_ready_o = 1'b1;

  rgbatm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: output register frees when empty or being taken; input
  // register frees when empty or moving into the output register.
  assign out_load    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || out_load;
  assign in_load     = in_valid_i && in_ready_o;

  assign in_valid_d  = in_load || (in_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  // One combiner per color channel, all driven by the same mode
  rgbatm_channel u_red (
    .mode_i   (cfg.mode),
    .first_i  (in_q.first_red),
    .second_i (in_q.second_red),
    .op_i     (cfg.op_red),
    .res_o    (res.out_red)
  );

  rgbatm_channel u_green (
    .mode_i   (cfg.mode),
    .first_i  (in_q.first_green),
    .second_i (in_q.second_green),
    .op_i     (cfg.op_grn),
    .res_o    (res.out_green)
  );

  rgbatm_channel u_blue (
    .mode_i   (cfg.mode),
    .first_i  (in_q.first_blue),
    .second_i (in_q.second_blue),
    .op_i     (cfg.op_blue),
    .res_o    (res.out_blue)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Accepted word always occupies the input register next cycle
  `RGBATM_ASSERT(a_accept_fills_in, (in_valid_i && in_ready_o) |=> in_valid_q)
  // Output word only appears after the input register held one
  `RGBATM_ASSERT(a_out_from_in, $rose(out_valid_q) |-> $past(in_valid_q))
  // Backpressure only when both stages are full
  `RGBATM_ASSERT(a_stall_full, !in_ready_o |-> (in_valid_q && out_valid_q))
  // A stalled input-stage word is not lost
  `RGBATM_NEVER(a_no_drop, in_valid_q && !out_load && !in_load && !in_valid_d)

endmodule

[tb/tb_rgb_arithmetic_transfer_modes.sv]
`timescale 1ns / 1ps

module tb_rgb_arithmetic_transfer_modes;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 8;
  // No handshake of any kind for this long means the block is hung.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Receiver hold-off used to back the pipe up into the input side.
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned HOLD_WORDS     = 40;
  localparam int unsigned BATCHES        = 16;
  localparam int unsigned BATCH_WORDS    = 30;
  // Pipe is two stages deep; a tail wait at the end catches stray output words.
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned CH_W           = rgbatm_pkg::CH_W;
  localparam int unsigned CFG_IDX_W      = rgbatm_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DAT_W      = rgbatm_pkg::CFG_DAT_W;

  // Mode code with no meaning: block must return black.
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  // First index past the register map; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = rgbatm_pkg::REG_OP_BLUE_LEVEL + 1'b1;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] dat;
  } reg_write_t;

  logic     clk;
  logic     rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rgbatm_pkg::pix_in_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rgbatm_pkg::pix_out_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Pending input words, register writes, and combined pixels still owed.
  rgbatm_pkg::pix_in_t  pixel_q[$];
  reg_write_t           reg_write_q[$];
  rgbatm_pkg::pix_out_t combined_q[$];

  // Shadow copy of the block's registers, updated on config handshakes.
  logic [2:0]      mode_r   = rgbatm_pkg::MODE_ADD_OVER;
  logic [CH_W-1:0] op_red_r = '0;
  logic [CH_W-1:0] op_grn_r = '0;
  logic [CH_W-1:0] op_blu_r = '0;

  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        send_pause     = 1'b0;

  // Long receiver hold: the stimulus bumps hold_req, the receiver notices
  // the change and counts the stretch down on its own.
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  rgb_arithmetic_transfer_modes dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: one channel of the combined pixel in the current mode.
  // ---------------------------------------------------------------------
  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] a,
                                                  logic [CH_W-1:0] b,
                                                  logic [CH_W-1:0] op);
    logic [CH_W:0] sum;
    int            diff;
    logic [63:0]   acc;
    logic [63:0]   full;
    sum  = {1'b0, a} + {1'b0, b};   // 17 bits, so add-pin never wraps
    diff = int'(a) - int'(b);       // signed, so sub-pin catches underflow
    full = {48'd0, rgbatm_pkg::FULL_SCALE};
    case (mode_r)
      rgbatm_pkg::MODE_ADD_OVER: return sum[CH_W-1:0];
      rgbatm_pkg::MODE_ADD_PIN:  return (sum < {1'b0, op}) ? sum[CH_W-1:0] : op;
      rgbatm_pkg::MODE_SUB_OVER: return a - b;
      rgbatm_pkg::MODE_SUB_PIN:  return (diff > int'(op)) ? diff[CH_W-1:0] : op;
      rgbatm_pkg::MODE_MIN:      return (a < b) ? a : b;
      rgbatm_pkg::MODE_MAX:      return (a > b) ? a : b;
      rgbatm_pkg::MODE_BLEND: begin
        // a*op + b*(full-op) over full scale, truncated
        acc = {48'd0, a} * {48'd0, op} + {48'd0, b} * (full - {48'd0, op});
        return CH_W'(acc / full);
      end
      default:                   return '0;
    endcase
  endfunction

  function automatic rgbatm_pkg::pix_out_t combine_pixel(rgbatm_pkg::pix_in_t p);
    rgbatm_pkg::pix_out_t r;
    r.out_red   = mix_channel(p.first_red,   p.second_red,   op_red_r);
    r.out_green = mix_channel(p.first_green, p.second_green, op_grn_r);
    r.out_blue  = mix_channel(p.first_blue,  p.second_blue,  op_blu_r);
    return r;
  endfunction

  task automatic check_channel(string name, logic [CH_W-1:0] want,
                               logic [CH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: feeds pixel_q onto the input channel. A new word is only
  // picked up once the current one is gone, so valid/data stay stable.
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold when one is requested.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: tracks register writes, predicts on input accept, checks on
  // output accept, and runs the watchdog.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rgbatm_pkg::pix_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rgbatm_pkg::REG_MODE_SELECT:   mode_r   = cfg_data[2:0];
          rgbatm_pkg::REG_OP_RED_LEVEL:  op_red_r = cfg_data;
          rgbatm_pkg::REG_OP_GRN_LEVEL:  op_grn_r = cfg_data;
          rgbatm_pkg::REG_OP_BLUE_LEVEL: op_blu_r = cfg_data;
          default: ;          // unmapped index: no effect
        endcase
      end

      if (out_valid && out_ready) begin
        if (combined_q.size() == 0) begin
          $display("%0t: unexpected word expected none got %h", $time, out_data);
          mismatches++;
        end else begin
          want = combined_q.pop_front();
          check_channel("out_red",   want.out_red,   out_data.out_red);
          check_channel("out_green", want.out_green, out_data.out_green);
          check_channel("out_blue",  want.out_blue,  out_data.out_blue);
        end
      end

      if (in_valid && in_ready)
        combined_q.push_back(combine_pixel(in_data));

      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Push the queued register writes back to back; valid stays high
  // between writes and drops only after the last one is taken.
  task automatic flush_reg_writes();
    reg_write_t w;
    @(posedge clk);
    while (reg_write_q.size() != 0) begin
      w = reg_write_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.dat;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [CFG_DAT_W-1:0] mode, logic [CH_W-1:0] r,
                          logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    reg_write_q.push_back('{rgbatm_pkg::REG_MODE_SELECT,   mode});
    reg_write_q.push_back('{rgbatm_pkg::REG_OP_RED_LEVEL,  r});
    reg_write_q.push_back('{rgbatm_pkg::REG_OP_GRN_LEVEL,  g});
    reg_write_q.push_back('{rgbatm_pkg::REG_OP_BLUE_LEVEL, b});
  endtask

  // Block is idle once nothing is queued, offered or owed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || combined_q.size() != 0);
  endtask

  // Mostly random, with a bias toward the channel extremes and half scale.
  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic rgbatm_pkg::pix_in_t random_pixel();
    rgbatm_pkg::pix_in_t p;
    p.first_red    = pick_level();
    p.first_green  = pick_level();
    p.first_blue   = pick_level();
    // Occasionally equal sources, for the min/max/sub ties.
    if ($urandom_range(7) == 0) begin
      p.second_red   = p.first_red;
      p.second_green = p.first_green;
      p.second_blue  = p.first_blue;
    end else begin
      p.second_red   = pick_level();
      p.second_green = pick_level();
      p.second_blue  = pick_level();
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [2:0]           dir_modes[8];
    logic [CFG_DAT_W-1:0] mode_word;
    int unsigned          phase;

    dir_modes = '{rgbatm_pkg::MODE_ADD_OVER, rgbatm_pkg::MODE_ADD_PIN,
                  rgbatm_pkg::MODE_SUB_OVER, rgbatm_pkg::MODE_SUB_PIN,
                  rgbatm_pkg::MODE_MIN, rgbatm_pkg::MODE_MAX,
                  rgbatm_pkg::MODE_BLEND, MODE_UNUSED};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every mode with levels at zero, full and half scale.
    // Full+full overflows add-pin at 17 bits, zero-full underflows sub-pin.
    foreach (dir_modes[i]) begin
      mode_word = {13'd0, dir_modes[i]};
      if (dir_modes[i] == MODE_UNUSED) begin
        // upper data bits must be dropped, and an unmapped write ignored
        mode_word = '1;
        reg_write_q.push_back('{REG_UNUSED, 16'hA5A5});
      end
      set_regs(mode_word, '0, '1, 16'h8000);
      flush_reg_writes();
      pixel_q.push_back('{'1, '1, '1, '1, '1, '1});
      pixel_q.push_back('{'0, '0, '0, '1, '1, '1});
      pixel_q.push_back('{16'hFFFF, 16'h0001, 16'h8000,
                          16'h0001, 16'hFFFF, 16'h7FFF});
      wait_idle();
    end

    // Random: each batch gets fresh registers and one of the flow-control
    // phases (none, sender gaps, receiver stalls, both).
    for (int b = 0; b < BATCHES; b++) begin
      phase = b % 4;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      set_regs(CFG_DAT_W'($urandom), pick_level(), pick_level(), pick_level());
      flush_reg_writes();

      for (int k = 0; k < BATCH_WORDS / 2; k++)
        pixel_q.push_back(random_pixel());

      // Once: let the pipe run dry before sending more.
      if (b == 5) begin
        wait (pixel_q.size() == 0);
        send_pause = 1'b1;
        do @(negedge clk); while (in_valid || combined_q.size() != 0);
        send_pause = 1'b0;
      end

      for (int k = BATCH_WORDS / 2; k < BATCH_WORDS; k++)
        pixel_q.push_back(random_pixel());

      // Once: hold the receiver off long enough to fill both stages
      // and push back on the sender, which keeps offering.
      if (b == 0) begin
        for (int k = 0; k < HOLD_WORDS; k++)
          pixel_q.push_back(random_pixel());
        hold_req++;
      end

      wait_idle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (combined_q.size() != 0) begin
      $display("%0t: words missing expected %0d more got none", $time,
               combined_q.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
